[hdl/assert_macros.svh]
// Assertion macros for the checker file of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

[hdl/ddo_pkg.sv]
// Shared types, opcodes and constants for the odometry block.
// No dependencies.
package ddo_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_X,
        ST_SQ,
        ST_SQ_TAKE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_T_MUL,
        ST_T_TAKE,
        ST_SIN_MUL,
        ST_SIN_TAKE,
        ST_STEP_X,
        ST_ADD_X,
        ST_ADD_Y,
        ST_DIVIDE,
        ST_SNAP_CHK,
        ST_SNAP_MUL,
        ST_SNAP_SET,
        ST_FINISH
    } t_state;

    localparam logic [1:0] OP_MOVE   = 2'd0;
    localparam logic [1:0] OP_SNAP_X = 2'd1;
    localparam logic [1:0] OP_SNAP_Y = 2'd2;

    localparam logic [15:0] DEG_360 = 16'd46080;
    localparam logic [15:0] DEG_270 = 16'd34560;
    localparam logic [15:0] DEG_180 = 16'd23040;
    localparam logic [15:0] DEG_90  = 16'd11520;
    localparam logic [15:0] DEG_45  = 16'd5760;

    localparam logic [31:0] RAD_Q30 = 32'd146409;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [23:0] GRID_RESET   = 24'd131072;
    localparam logic [23:0] WINDOW_RESET = 24'd16384;

    // Series divisors: sine terms first, then cosine terms.
    function automatic logic [6:0] div_const(input logic [2:0] idx);
        logic [6:0] d;
        case (idx)
            3'd0:    d = 7'd72;
            3'd1:    d = 7'd42;
            3'd2:    d = 7'd20;
            3'd3:    d = 7'd6;
            3'd4:    d = 7'd56;
            3'd5:    d = 7'd30;
            3'd6:    d = 7'd12;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] recip(input logic [2:0] idx);
        logic [31:0] m;
        case (idx)
            3'd0:    m = 32'd59652323;
            3'd1:    m = 32'd102261126;
            3'd2:    m = 32'd214748364;
            3'd3:    m = 32'd715827882;
            3'd4:    m = 32'd76695844;
            3'd5:    m = 32'd143165576;
            3'd6:    m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

[hdl/ddo_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
// No dependencies.
module ddo_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/differential_drive_odometry.sv]
// Top level of the dead-reckoning odometry block: sequencer and datapath.
// Depends on ddo_pkg and ddo_mul.
//
// Usage: one input channel (i_in_valid / o_in_ready) takes a transaction of
// opcode, heading and two wheel powers; one output channel (o_out_valid /
// i_out_ready) returns the x and y position after that transaction.
// Move: from accept to result the sequencer forms the angle and its square,
// runs the sine and cosine series (eight reciprocal divides and seven series
// products through the one shared multiplier), makes the two position steps
// and loads the output register. Snap: a bit-serial grid division, then a
// rounding and window check and, when the position lies inside the window,
// a product with the grid pitch that sets it; snaps with zero grid or window
// and unused opcodes go straight to the output register. One transaction is
// in flight at a time; o_in_ready is high only when the sequencer is idle.
// The result sits in an output register, so a new transaction is accepted
// while it waits; if the receiver still stalls when the next result is done,
// the sequencer holds. Reset clears position and wheel state and loads the
// default grid pitch and snap window. Registers: grid_pitch at 0x0,
// snap_window at 0x4.
module differential_drive_odometry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_heading,
    input  logic signed [15:0] i_left_power,
    input  logic signed [15:0] i_right_power,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ddo_pkg::t_state r_state, n_state;

    logic [23:0] r_grid, r_window;
    logic [15:0] r_left, r_right;
    logic [31:0] r_x_pos, r_y_pos;
    logic [12:0] r_u;
    logic [1:0]  r_quad;
    logic        r_swap;
    logic [17:0] r_speed_mag;
    logic        r_speed_neg;
    logic [29:0] r_xr, r_x2, r_v;
    logic [30:0] r_t, r_sin, r_cos;
    logic        r_chain;
    logic [1:0]  r_term;
    logic        r_snap_y, r_neg;
    logic [31:0] r_div;
    logic [24:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    logic [31:0] r_out_x, r_out_y;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Configuration port
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {8'd0, r_window} : {8'd0, r_grid};

    logic in_acc;
    assign o_in_ready = (r_state == ddo_pkg::ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;

    // Wheel averaging, truncated toward zero
    logic [16:0] l_sum, r_sum, l_adj, r_adj;
    logic [15:0] nl, nr;
    logic [16:0] spd_sum, spd_abs;
    assign l_sum = {i_left_power[15], i_left_power} + {r_left[15], r_left};
    assign r_sum = {i_right_power[15], i_right_power} + {r_right[15], r_right};
    assign l_adj = l_sum + 17'(l_sum[16]);
    assign r_adj = r_sum + 17'(r_sum[16]);
    assign nl = l_adj[16:1];
    assign nr = r_adj[16:1];
    assign spd_sum = {nl[15], nl} + {nr[15], nr};
    assign spd_abs = spd_sum[16] ? (17'd0 - spd_sum) : spd_sum;

    // Heading reduction to quadrant and octant angle
    logic [15:0] a_wrap, a_rel, a_base;
    logic [1:0]  a_quad;
    logic        a_swap;
    logic [15:0] a_u;
    always_comb begin
        a_wrap = i_heading[15] ? (i_heading + ddo_pkg::DEG_360) : i_heading;
        if (a_wrap >= ddo_pkg::DEG_270) begin
            a_quad = 2'd3;
            a_base = ddo_pkg::DEG_270;
        end else if (a_wrap >= ddo_pkg::DEG_180) begin
            a_quad = 2'd2;
            a_base = ddo_pkg::DEG_180;
        end else if (a_wrap >= ddo_pkg::DEG_90) begin
            a_quad = 2'd1;
            a_base = ddo_pkg::DEG_90;
        end else begin
            a_quad = 2'd0;
            a_base = 16'd0;
        end
        a_rel  = a_wrap - a_base;
        a_swap = (a_rel > ddo_pkg::DEG_45);
        a_u    = a_swap ? (ddo_pkg::DEG_90 - a_rel) : a_rel;
    end

    // Constant divide correction
    logic [2:0]  idx;
    logic [29:0] fq0, fq;
    logic [6:0]  dv;
    logic [36:0] fqd;
    logic [30:0] frem, t_new;
    assign idx   = {r_chain, r_term};
    assign dv    = ddo_pkg::div_const(idx);
    assign fq0   = prod[61:32];
    assign fqd   = 37'(fq0) * 37'(dv);
    assign frem  = {1'b0, r_v} - fqd[30:0];
    assign fq    = fq0 + 30'(frem >= 31'(dv));
    assign t_new = ddo_pkg::ONE_Q30 - {1'b0, fq};

    // Octant and quadrant signs
    logic [30:0] s0, c0, cos_mag, sin_mag;
    logic        cos_neg, sin_neg;
    always_comb begin
        s0 = r_swap ? r_cos : r_sin;
        c0 = r_swap ? r_sin : r_cos;
        case (r_quad)
            2'd0: begin
                cos_mag = c0; cos_neg = 1'b0; sin_mag = s0; sin_neg = 1'b0;
            end
            2'd1: begin
                cos_mag = s0; cos_neg = 1'b1; sin_mag = c0; sin_neg = 1'b0;
            end
            2'd2: begin
                cos_mag = c0; cos_neg = 1'b1; sin_mag = s0; sin_neg = 1'b1;
            end
            default: begin
                cos_mag = s0; cos_neg = 1'b0; sin_mag = c0; sin_neg = 1'b1;
            end
        endcase
    end

    function automatic logic [31:0] add_step(input logic [31:0] pos,
                                             input logic [63:0] p,
                                             input logic neg);
        logic [63:0] rnd;
        logic [19:0] mag;
        logic [32:0] delta, sum;
        logic [31:0] res;
        rnd   = p + 64'h2000_0000;
        mag   = rnd[49:30];
        delta = neg ? (33'd0 - {13'd0, mag}) : {13'd0, mag};
        sum   = {pos[31], pos} + delta;
        if (sum[32] != sum[31]) begin
            res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

    // Snap helpers
    logic [31:0] snap_p, snap_abs;
    logic [24:0] rem_sh;
    logic        div_ge;
    logic [23:0] s_rem, s_dist;
    logic        s_up;
    logic [32:0] s_mag;
    logic [31:0] s_res;
    always_comb begin
        snap_p   = (i_opcode == ddo_pkg::OP_SNAP_Y) ? r_y_pos : r_x_pos;
        snap_abs = snap_p[31] ? (32'd0 - snap_p) : snap_p;
        rem_sh   = {r_rem[23:0], r_div[31]};
        div_ge   = (rem_sh >= {1'b0, r_grid});
        s_rem    = r_rem[23:0];
        s_up     = ({s_rem, 1'b0} >= {1'b0, r_grid});
        s_dist   = s_up ? (r_grid - s_rem) : s_rem;
        s_mag    = prod[32:0];
        if (r_neg) begin
            s_res = (s_mag > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - s_mag[31:0]);
        end else begin
            s_res = (s_mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : s_mag[31:0];
        end
    end

    // Next state and multiplier operands
    always_comb begin
        n_state = r_state;
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        ddo_pkg::OP_MOVE: n_state = ddo_pkg::ST_X;
                        ddo_pkg::OP_SNAP_X, ddo_pkg::OP_SNAP_Y: begin
                            if (r_grid == 24'd0 || r_window == 24'd0) begin
                                n_state = ddo_pkg::ST_FINISH;
                            end else begin
                                n_state = ddo_pkg::ST_DIVIDE;
                            end
                        end
                        default: n_state = ddo_pkg::ST_FINISH;
                    endcase
                end
            end
            ddo_pkg::ST_X: begin
                mul_a   = {19'd0, r_u};
                mul_b   = ddo_pkg::RAD_Q30;
                n_state = ddo_pkg::ST_SQ;
            end
            ddo_pkg::ST_SQ: begin
                mul_a   = prod[31:0];
                mul_b   = prod[31:0];
                n_state = ddo_pkg::ST_SQ_TAKE;
            end
            ddo_pkg::ST_SQ_TAKE: n_state = ddo_pkg::ST_DIV_MUL;
            ddo_pkg::ST_DIV_MUL: begin
                mul_a   = {2'd0, r_v};
                mul_b   = ddo_pkg::recip(idx);
                n_state = ddo_pkg::ST_DIV_FIX;
            end
            ddo_pkg::ST_DIV_FIX: begin
                if (r_term != 2'd3) begin
                    n_state = ddo_pkg::ST_T_MUL;
                end else if (!r_chain) begin
                    n_state = ddo_pkg::ST_SIN_MUL;
                end else begin
                    n_state = ddo_pkg::ST_STEP_X;
                end
            end
            ddo_pkg::ST_T_MUL: begin
                mul_a   = {2'd0, r_x2};
                mul_b   = {1'b0, r_t};
                n_state = ddo_pkg::ST_T_TAKE;
            end
            ddo_pkg::ST_T_TAKE: n_state = ddo_pkg::ST_DIV_MUL;
            ddo_pkg::ST_SIN_MUL: begin
                mul_a   = {2'd0, r_xr};
                mul_b   = {1'b0, r_t};
                n_state = ddo_pkg::ST_SIN_TAKE;
            end
            ddo_pkg::ST_SIN_TAKE: n_state = ddo_pkg::ST_DIV_MUL;
            ddo_pkg::ST_STEP_X: begin
                mul_a   = {14'd0, r_speed_mag};
                mul_b   = {1'b0, cos_mag};
                n_state = ddo_pkg::ST_ADD_X;
            end
            ddo_pkg::ST_ADD_X: begin
                mul_a   = {14'd0, r_speed_mag};
                mul_b   = {1'b0, sin_mag};
                n_state = ddo_pkg::ST_ADD_Y;
            end
            ddo_pkg::ST_ADD_Y: n_state = ddo_pkg::ST_FINISH;
            ddo_pkg::ST_DIVIDE: begin
                if (r_cnt == 5'd31) begin
                    n_state = ddo_pkg::ST_SNAP_CHK;
                end
            end
            ddo_pkg::ST_SNAP_CHK: begin
                n_state = (s_dist >= r_window) ? ddo_pkg::ST_FINISH : ddo_pkg::ST_SNAP_MUL;
            end
            ddo_pkg::ST_SNAP_MUL: begin
                mul_a   = r_div;
                mul_b   = {8'd0, r_grid};
                n_state = ddo_pkg::ST_SNAP_SET;
            end
            ddo_pkg::ST_SNAP_SET: n_state = ddo_pkg::ST_FINISH;
            ddo_pkg::ST_FINISH: begin
                if (!r_out_valid) begin
                    n_state = ddo_pkg::ST_IDLE;
                end
            end
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Architectural state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid      <= ddo_pkg::GRID_RESET;
            r_window    <= ddo_pkg::WINDOW_RESET;
            r_left      <= 16'd0;
            r_right     <= 16'd0;
            r_x_pos     <= 32'd0;
            r_y_pos     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_window <= pwdata[23:0];
                end else begin
                    r_grid <= pwdata[23:0];
                end
            end
            if (in_acc && i_opcode == ddo_pkg::OP_MOVE) begin
                r_left  <= nl;
                r_right <= nr;
            end
            case (r_state)
                ddo_pkg::ST_ADD_X: r_x_pos <= add_step(r_x_pos, prod, r_speed_neg ^ cos_neg);
                ddo_pkg::ST_ADD_Y: r_y_pos <= add_step(r_y_pos, prod, r_speed_neg ^ sin_neg);
                ddo_pkg::ST_SNAP_SET: begin
                    if (r_snap_y) begin
                        r_y_pos <= s_res;
                    end else begin
                        r_x_pos <= s_res;
                    end
                end
                default: ;
            endcase
            if (r_state == ddo_pkg::ST_FINISH && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_u         <= a_u[12:0];
            r_quad      <= a_quad;
            r_swap      <= a_swap;
            r_speed_mag <= {spd_abs, 1'b0};
            r_speed_neg <= spd_sum[16];
            r_snap_y    <= (i_opcode == ddo_pkg::OP_SNAP_Y);
            r_neg       <= snap_p[31];
            r_div       <= snap_abs;
            r_rem       <= 25'd0;
            r_cnt       <= 5'd0;
        end
        case (r_state)
            ddo_pkg::ST_SQ: r_xr <= prod[29:0];
            ddo_pkg::ST_SQ_TAKE: begin
                r_x2    <= prod[59:30];
                r_v     <= prod[59:30];
                r_chain <= 1'b0;
                r_term  <= 2'd0;
            end
            ddo_pkg::ST_DIV_FIX: begin
                r_t <= t_new;
                if (r_term == 2'd3 && r_chain) begin
                    r_cos <= t_new;
                end
                if (r_term != 2'd3) begin
                    r_term <= r_term + 2'd1;
                end
            end
            ddo_pkg::ST_T_TAKE: r_v <= prod[59:30];
            ddo_pkg::ST_SIN_TAKE: begin
                r_sin   <= prod[60:30];
                r_chain <= 1'b1;
                r_term  <= 2'd0;
                r_v     <= r_x2;
            end
            ddo_pkg::ST_DIVIDE: begin
                // one quotient bit per cycle
                r_rem <= div_ge ? (rem_sh - {1'b0, r_grid}) : rem_sh;
                r_div <= {r_div[30:0], div_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            ddo_pkg::ST_SNAP_CHK: r_div <= r_div + 32'(s_up);
            ddo_pkg::ST_FINISH: begin
                if (!r_out_valid) begin
                    r_out_x <= r_x_pos;
                    r_out_y <= r_y_pos;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;

endmodule

[hdl/ddo_checker.sv]
// Port-level checks for the odometry block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ddo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pos_x,
    input logic [31:0] o_pos_y
);

    // Stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x) && $stable(o_pos_y))

    // Busy after a transaction is taken
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // No result directly after one is delivered
    `ASSERT_CLK(a_single_result, i_clk, i_rst_n, o_out_valid && i_out_ready |=> !o_out_valid)

    // A new result shows up only out of a busy cycle
    `ASSERT_NEVER(a_result_from_idle, i_clk, i_rst_n, $rose(o_out_valid) && $past(o_in_ready))

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y)
);

[tb/testbench.sv]
// Self-checking testbench for the differential_drive_odometry block.
// Depends on ddo_pkg and the block's RTL; drives moves, snaps and unused opcodes, predicts
// the position after each transaction and compares it with the output.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] heading;
        logic signed [15:0] left_power;
        logic signed [15:0] right_power;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_pos;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_GRID = 3'd0;
    localparam logic [2:0] ADDR_WINDOW = 3'd4;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic signed [15:0] heading;
    logic signed [15:0] left_power;
    logic signed [15:0] right_power;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    differential_drive_odometry u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_heading(heading),
        .i_left_power(left_power), .i_right_power(right_power),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_y(pos_y),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [23:0]        pred_grid;
    logic [23:0]        pred_window;
    logic signed [31:0] wheel_left;
    logic signed [31:0] wheel_right;
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;

    t_cmd cmd_queue[$];
    t_pos expected_pos[$];
    int   errors;
    int   n_moves;
    int   n_snaps;
    int   n_results;
    bit   quiet;
    int   send_gap;
    int   recv_gap;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Taylor sine and cosine of an octant angle, Q2.30
    function automatic void octant_trig(input longint unsigned u,
                                        output longint unsigned s,
                                        output longint unsigned c);
        longint unsigned one;
        longint unsigned rad;
        longint unsigned rad2;
        longint unsigned t;
        one = 64'd1 << 30;
        rad = u * 146409;
        rad2 = (rad * rad) >> 30;
        t = one - rad2 / 72;
        t = one - ((rad2 * t) >> 30) / 42;
        t = one - ((rad2 * t) >> 30) / 20;
        t = one - ((rad2 * t) >> 30) / 6;
        s = (rad * t) >> 30;
        t = one - rad2 / 56;
        t = one - ((rad2 * t) >> 30) / 30;
        t = one - ((rad2 * t) >> 30) / 12;
        t = one - ((rad2 * t) >> 30) / 2;
        c = t;
    endfunction

    function automatic void heading_trig(input int h, output longint sn, output longint cs);
        int a;
        int quad;
        int rem;
        longint unsigned s0;
        longint unsigned c0;
        a = h;
        while (a < 0) a += 46080;
        while (a >= 46080) a -= 46080;
        quad = a / 11520;
        rem = a - quad * 11520;
        if (rem <= 5760) octant_trig(rem, s0, c0);
        else octant_trig(11520 - rem, c0, s0);
        case (quad)
            0: begin cs = c0; sn = s0; end
            1: begin cs = -longint'(s0); sn = c0; end
            2: begin cs = -longint'(c0); sn = -longint'(s0); end
            default: begin cs = s0; sn = -longint'(c0); end
        endcase
    endfunction

    function automatic longint step_len(input longint spd, input longint trig);
        bit neg;
        longint unsigned ms;
        longint unsigned mt;
        longint unsigned m;
        neg = (spd < 0) != (trig < 0);
        ms = spd < 0 ? -spd : spd;
        mt = trig < 0 ? -trig : trig;
        m = (ms * mt + (64'd1 << 29)) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] snap_to_grid(input logic signed [31:0] p);
        longint unsigned g;
        longint unsigned m;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned d;
        longint snapped;
        g = pred_grid;
        if (g == 0 || pred_window == 0) return p;
        m = p < 0 ? -longint'(p) : longint'(p);
        q = m / g;
        rem = m - q * g;
        if (2 * rem >= g) begin
            q++;
            d = g - rem;
        end else begin
            d = rem;
        end
        if (d >= pred_window) return p;
        snapped = q * g;
        if (p < 0) snapped = -snapped;
        return clamp32(snapped);
    endfunction

    function automatic t_pos next_position(input t_cmd c);
        int nl;
        int nr;
        longint spd;
        longint sn;
        longint cs;
        t_pos r;
        if (c.opcode == ddo_pkg::OP_MOVE) begin
            nl = (int'(c.left_power) + wheel_left) / 2;
            nr = (int'(c.right_power) + wheel_right) / 2;
            spd = (longint'(nl) + nr) * 2;
            heading_trig(c.heading, sn, cs);
            track_x = clamp32(longint'(track_x) + step_len(spd, cs));
            track_y = clamp32(longint'(track_y) + step_len(spd, sn));
            wheel_left = nl;
            wheel_right = nr;
        end else if (c.opcode == ddo_pkg::OP_SNAP_X) begin
            track_x = snap_to_grid(track_x);
        end else if (c.opcode == ddo_pkg::OP_SNAP_Y) begin
            track_y = snap_to_grid(track_y);
        end
        r.pos_x = track_x;
        r.pos_y = track_y;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        t_cmd c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0 && !(quiet == 0 && $urandom_range(5) == 0)) begin
                c = cmd_queue.pop_front();
                expected_pos.push_back(next_position(c));
                if (c.opcode == ddo_pkg::OP_MOVE) n_moves++;
                else n_snaps++;
                opcode <= c.opcode;
                heading <= c.heading;
                left_power <= c.left_power;
                right_power <= c.right_power;
                in_valid <= 1'b1;
            end else begin
                if (!quiet && cmd_queue.size() > 0) send_gap <= $urandom_range(3);
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_pos e;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (expected_pos.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d", $time, pos_x, pos_y);
                    errors++;
                end else begin
                    e = expected_pos.pop_front();
                    if (pos_x !== e.pos_x) begin
                        $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, pos_x);
                        errors++;
                    end
                    if (pos_y !== e.pos_y) begin
                        $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, pos_y);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                recv_gap <= $urandom_range(3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [23:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {8'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_GRID) pred_grid = value;
        else pred_window = value;
    endtask

    task automatic drain;
        while (cmd_queue.size() > 0 || expected_pos.size() > 0 || in_valid) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic t_cmd make_cmd(input logic [1:0] op, input int h,
                                      input int lp, input int rp);
        t_cmd c;
        c.opcode = op;
        c.heading = 16'(h);
        c.left_power = 16'(lp);
        c.right_power = 16'(rp);
        return c;
    endfunction

    // mostly moves in range, some snaps, odd headings and the unused opcode
    task automatic queue_random(input int count);
        int k;
        int sel;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 60)
                cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, $urandom_range(46080) - 23040,
                                             $urandom_range(65535), $urandom_range(65535)));
            else if (sel < 68)
                cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, $urandom_range(65535),
                                             $urandom_range(65535), $urandom_range(65535)));
            else if (sel < 82)
                cmd_queue.push_back(make_cmd(ddo_pkg::OP_SNAP_X, $urandom_range(65535), 0, 0));
            else if (sel < 96)
                cmd_queue.push_back(make_cmd(ddo_pkg::OP_SNAP_Y, $urandom_range(65535), 0, 0));
            else
                cmd_queue.push_back(make_cmd(OP_UNUSED, $urandom_range(65535),
                                             $urandom_range(65535), $urandom_range(65535)));
        end
    endtask

    initial begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = ddo_pkg::OP_MOVE;
        heading = '0;
        left_power = '0;
        right_power = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        n_moves = 0;
        n_snaps = 0;
        n_results = 0;
        quiet = 1'b0;
        pred_grid = ddo_pkg::GRID_RESET;
        pred_window = ddo_pkg::WINDOW_RESET;
        wheel_left = 0;
        wheel_right = 0;
        track_x = 0;
        track_y = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: heading extremes, octant edges, power extremes, snaps
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, 0, 32767, 32767));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, 5760, 32767, 32767));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, 11520, -32768, 32767));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, 23040, -32768, -32768));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, -23040, -32768, -32768));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, -5761, 12345, -1));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, 32767, 1, 1));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, -32768, -1, -1));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_SNAP_X, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ddo_pkg::OP_SNAP_Y, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_UNUSED, -1, -1, -1));
        drain();

        // drive toward saturation with full power along the axes
        for (k = 0; k < 12; k++)
            cmd_queue.push_back(make_cmd(ddo_pkg::OP_MOVE, (k % 2) ? 11520 : 0, 32767, 32767));
        queue_random(300);
        drain();

        reg_write(ADDR_GRID, 24'd1);
        reg_write(ADDR_WINDOW, 24'hffffff);
        queue_random(300);
        drain();

        reg_write(ADDR_GRID, 24'd8388608);
        reg_write(ADDR_WINDOW, 24'd8388608);
        queue_random(300);
        drain();

        reg_write(ADDR_GRID, 24'hffffff);
        reg_write(ADDR_WINDOW, 24'd0);
        queue_random(200);
        drain();

        reg_write(ADDR_GRID, 24'd0);
        reg_write(ADDR_WINDOW, 24'd1000);
        queue_random(200);
        drain();

        reg_write(ADDR_GRID, 24'd65536);
        reg_write(ADDR_WINDOW, 24'd20000);
        queue_random(400);
        drain();

        reg_write(ADDR_GRID, 24'($urandom_range(24'hffffff, 1)));
        reg_write(ADDR_WINDOW, 24'($urandom_range(24'hffffff)));
        quiet = 1'b1;
        queue_random(230);
        drain();

        $display("covered %0d moves and %0d snap or unused transactions, %0d results",
                 n_moves, n_snaps, n_results);
        if (errors == 0 && expected_pos.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/differential_drive_odometry.sv
hdl/ddo_checker.sv
tb/testbench.sv
